### rtl/core/wfsr_pkg.sv
// Shared types, default sizes and unit widths of the waterfall spectrum row block.
`timescale 1ns / 1ps
package wfsr_pkg;

  localparam int BINS_DEFAULT      = 64;
  localparam int ROWS_DEFAULT      = 180;
  localparam int MAX_CHUNK_DEFAULT = 2048;

  // Widths of the shared iterative divider.
  localparam int DIV_DW = 64;
  localparam int DIV_SW = 32;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_SW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] phase;
  } sin_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] value;
  } sin_rsp_t;

endpackage

### rtl/core/wfsr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wfsr_div (
  input  logic               clk,
  input  logic               rst,
  input  wfsr_pkg::div_req_t req,
  output wfsr_pkg::div_rsp_t rsp
);
  import wfsr_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] quo;
  logic [DIV_SW-1:0] rem;
  logic [DIV_SW-1:0] dsr;
  logic [DIV_SW:0]   trial;
  logic [DIV_SW:0]   diff;
  logic              fit;

  always_comb begin
    trial = {rem, quo[DIV_DW-1]};
    diff  = trial - {1'b0, dsr};
    fit   = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[DIV_DW-2:0], fit};
        rem <= fit ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### rtl/core/wfsr_sin.sv
// Sine of a 32-bit phase in Q15 from a quadrant polynomial on one shared multiplier.
`timescale 1ns / 1ps
module wfsr_sin (
  input  logic               clk,
  input  logic               rst,
  input  wfsr_pkg::sin_req_t req,
  output wfsr_pkg::sin_rsp_t rsp
);
  import wfsr_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic               busy;
  logic               done;
  logic [2:0]         step;
  logic [16:0]        x;
  logic [16:0]        x2;
  logic               neg;
  logic signed [23:0] t;
  logic signed [15:0] value;
  logic [16:0]        x_in;
  logic signed [23:0] ma;
  logic signed [17:0] mb;
  logic signed [41:0] prod;
  logic signed [41:0] pshift;
  logic signed [41:0] yfull;
  logic signed [15:0] y;
  logic signed [23:0] coef;

  always_comb begin
    // Odd quadrants run the argument backward from the quarter turn.
    x_in = req.phase[30] ? (17'd65536 - {1'b0, req.phase[29:14]}) : {1'b0, req.phase[29:14]};
    ma = t;
    mb = $signed({1'b0, x2});
    if (step == 3'd0) begin
      ma = $signed({7'b0, x});
      mb = $signed({1'b0, x});
    end else if (step == LAST_STEP) begin
      mb = $signed({1'b0, x});
    end
    prod   = ma * mb;
    pshift = prod >>> 16;
    yfull  = (pshift + 42'sd16) >>> 5;
    if (yfull > 42'sd32767) begin
      y = 16'sd32767;
    end else if (yfull < 42'sd0) begin
      y = 16'sd0;
    end else begin
      y = yfull[15:0];
    end
    case (step)
      3'd1:    coef = -24'sd4909;
      3'd2:    coef = 24'sd83565;
      3'd3:    coef = -24'sd677340;
      3'd4:    coef = 24'sd1647099;
      default: coef = 24'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= x_in;
        neg  <= req.phase[31];
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 3'd0) begin
          x2 <= prod[32:16];
          t  <= 24'sd168;
        end else if (step == LAST_STEP) begin
          value <= neg ? -y : y;
          busy  <= 1'b0;
          done  <= 1'b1;
        end else begin
          t <= coef + $signed(pshift[23:0]);
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

### rtl/core/waterfall_spectrum_row.sv
// Top level: sample store, windowed single-bin transforms, dB averaging and heat-map pixels.
// A chunk of N samples is worked through bin by bin; its processing time is set by the shared
// sine unit (six multiply steps, three calls per sample and bin) and the 64-step divider,
// and the pixels follow with one pixel in flight.
// Input is refused while a chunk is processed; the last pixel may wait while samples arrive.
// Reset clears the sample count, row and averages (-72 dB floor, -18 dB ceiling) at once.
`timescale 1ns / 1ps
module waterfall_spectrum_row #(
  parameter int BINS      = wfsr_pkg::BINS_DEFAULT,
  parameter int ROWS      = wfsr_pkg::ROWS_DEFAULT,
  parameter int MAX_CHUNK = wfsr_pkg::MAX_CHUNK_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         row_index,
  output logic [5:0]         bin_index,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               row_done
);
  import wfsr_pkg::*;

  localparam int AW    = $clog2(MAX_CHUNK);
  localparam int CW    = $clog2(MAX_CHUNK + 1);
  localparam int BW    = $clog2(BINS);
  localparam int RW    = $clog2(ROWS);
  localparam int KW    = $clog2(MAX_CHUNK + BINS + 1);
  // Each windowed product is below 2^45 in magnitude; the sum of MAX_CHUNK of them fits here.
  localparam int ACC_W = 48 + AW;
  localparam int SH_W  = $clog2(ACC_W);

  localparam logic signed [17:0] FLOOR_INIT = -18'sd18432;
  localparam logic signed [17:0] CEIL_INIT  = -18'sd4608;
  localparam logic signed [17:0] CEIL_GAP   = 18'sd4608;
  localparam logic signed [17:0] MIN_RANGE  = 18'sd6144;
  localparam logic signed [15:0] MAX_INIT   = -16'sd30720;
  localparam logic signed [17:0] FLOOR_KEEP = 18'sd62915;
  localparam logic signed [17:0] MIN_GAIN   = 18'sd2621;
  localparam logic signed [17:0] CEIL_KEEP  = 18'sd58982;
  localparam logic signed [17:0] MAX_GAIN   = 18'sd6554;
  localparam logic signed [19:0] DB_SCALE   = 20'sd394566;
  localparam logic [31:0]        QUARTER    = 32'h4000_0000;
  localparam logic [CW-1:0]      MIN_CHUNK  = CW'(8);

  typedef enum logic [4:0] {
    ST_IDLE, ST_WDIV, ST_BIN, ST_PDIV, ST_SRD, ST_WIN, ST_XW,
    ST_COS, ST_MRE, ST_SIN, ST_MIM, ST_ABS, ST_NORM, ST_SQA, ST_SQB,
    ST_SQRT, ST_MST, ST_MDIV, ST_LNRM, ST_LSQ, ST_DB, ST_DBW, ST_AVG,
    ST_CLAMP, ST_RANGE, ST_PRD, ST_PNUM, ST_LDIV, ST_PCOL, ST_PGRN, ST_PEMIT
  } state_t;

  state_t state;

  // Sample store and per-bin dB store, both with registered reads.
  logic signed [15:0] sample_mem [MAX_CHUNK];
  logic signed [15:0] spec_mem [BINS];
  logic signed [15:0] sample_rd;
  logic signed [15:0] spec_rd;

  logic [CW-1:0]  count;
  logic [CW-1:0]  n;
  logic [AW-1:0]  i;
  logic [BW-1:0]  bin;
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  kq;
  logic [KW-1:0]  kr;

  // Phases kept as quotient and remainder of m*2^32 over the divisor, stepped without division.
  logic [31:0]    wk_q, pk_q, w_q, d_q;
  logic [CW-1:0]  wk_r, pk_r, w_r, d_r;

  logic signed [15:0]      win;
  logic signed [31:0]      xw;
  logic signed [15:0]      trig;
  logic signed [ACC_W-1:0] re, im;
  logic [ACC_W-1:0]        mag_a, mag_b;
  logic [SH_W-1:0]         sh;
  logic [63:0]             sq_x, sq_res, sq_bit;
  logic [4:0]              it_cnt;
  logic [63:0]             lm;
  logic signed [7:0]       le;
  logic [11:0]             frac;
  logic signed [39:0]      dbacc;
  logic signed [15:0]      row_min, row_max;
  logic signed [17:0]      floor_db, ceil_db;
  logic signed [39:0]      avg_acc;
  logic [2:0]              avg_step;
  logic [17:0]             range_db;
  logic [16:0]             lv;
  logic [26:0]             rprod;
  logic [27:0]             gprod;
  logic [26:0]             bprod;
  logic [27:0]             gq;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sin_req_t sin_req;
  sin_rsp_t sin_rsp;

  wfsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wfsr_sin u_sin (
    .clk (clk),
    .rst (rst),
    .req (sin_req),
    .rsp (sin_rsp)
  );

  logic               in_fire;
  logic               has_room;
  logic [CW-1:0]      n_new;
  logic [CW-1:0]      nm1;
  logic [CW-1:0]      half_m1;
  logic [CW:0]        w_sum, d_sum;
  logic               w_wrap, d_wrap;
  logic [31:0]        w_q_next, d_q_next;
  logic [CW-1:0]      w_r_next, d_r_next;
  logic signed [47:0] xt;
  logic [ACC_W-1:0]   ab_or;
  logic [30:0]        sq_op;
  logic [61:0]        sq_prod;
  logic [63:0]        sq_sum;
  logic               sq_fit;
  logic [63:0]        lsq;
  logic [33:0]        lsq_sh;
  logic signed [19:0] l12;
  logic signed [39:0] db_prod;
  logic signed [15:0] db;
  logic signed [17:0] avg_x, avg_k;
  logic signed [39:0] avg_prod;
  logic signed [17:0] ceil_lim;
  logic signed [17:0] span;
  logic signed [18:0] num;
  logic [18:0]        g5;
  logic [26:0]        r_mul;
  logic [27:0]        g_mul;
  logic [26:0]        b_mul;
  logic [27:0]        gq_mul;
  logic               pix_emit;

  always_comb begin
    in_ready = (state == ST_IDLE);
    in_fire  = in_valid && in_ready;
    has_room = count < CW'(MAX_CHUNK);
    n_new    = has_room ? count + 1'b1 : count;
    nm1      = n - 1'b1;
    half_m1  = (n >> 1) - 1'b1;

    // Window phase steps by 2^32/(N-1), transform phase by k*2^32/N; both wrap mod 2^32.
    w_sum    = {1'b0, w_r} + {1'b0, wk_r};
    w_wrap   = w_sum >= {1'b0, nm1};
    w_q_next = w_q + wk_q + {31'b0, w_wrap};
    w_r_next = w_wrap ? CW'(w_sum - {1'b0, nm1}) : w_sum[CW-1:0];
    d_sum    = {1'b0, d_r} + {1'b0, pk_r};
    d_wrap   = d_sum >= {1'b0, n};
    d_q_next = d_q + pk_q + {31'b0, d_wrap};
    d_r_next = d_wrap ? CW'(d_sum - {1'b0, n}) : d_sum[CW-1:0];

    // Windowed sample times cosine or sine, wide enough for the full product.
    xt = xw * trig;

    ab_or   = mag_a | mag_b;
    sq_op   = (state == ST_SQB) ? mag_b[30:0] : mag_a[30:0];
    sq_prod = sq_op * sq_op;
    sq_sum  = sq_res + sq_bit;
    sq_fit  = sq_x >= sq_sum;

    lsq     = lm[31:0] * lm[31:0];
    lsq_sh  = lsq[63:30];
    l12     = $signed({le - 8'sd32, frac});
    db_prod = l12 * DB_SCALE;
    db      = dbacc[35:20];

    // One shared multiplier for the floor and ceiling averages, one term per step.
    case (avg_step)
      3'd0: begin
        avg_x = floor_db;
        avg_k = FLOOR_KEEP;
      end
      3'd1: begin
        avg_x = 18'(row_min);
        avg_k = MIN_GAIN;
      end
      3'd2: begin
        avg_x = ceil_db;
        avg_k = CEIL_KEEP;
      end
      default: begin
        avg_x = 18'(row_max);
        avg_k = MAX_GAIN;
      end
    endcase
    avg_prod = avg_x * avg_k;

    ceil_lim = floor_db + CEIL_GAP;
    span     = ceil_db - floor_db;
    num      = $signed({{3{spec_rd[15]}}, spec_rd}) - $signed({floor_db[17], floor_db});
    g5       = {lv, 2'b00} + {2'b00, lv};
    r_mul    = lv * 10'd561;
    g_mul    = (g5 - 19'd65536) * 9'd459;
    b_mul    = (17'd65536 - lv) * 10'd663;
    gq_mul   = gprod[27:16] * 16'd52429;
    pix_emit = (state == ST_PEMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_room) begin
      sample_mem[count[AW-1:0]] <= sample;
    end
    sample_rd <= sample_mem[i];
    if (state == ST_DBW) begin
      spec_mem[bin] <= db;
    end
    spec_rd <= spec_mem[bin];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      cur_row       <= '0;
      floor_db      <= FLOOR_INIT;
      ceil_db       <= CEIL_INIT;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      sin_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      sin_req.start <= 1'b0;
      if (pix_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count <= n_new;
            if (last_sample) begin
              // A last mark always closes the chunk, even when its sample was dropped.
              count <= '0;
              n     <= n_new;
              if (n_new >= MIN_CHUNK) begin
                div_req.start    <= 1'b1;
                div_req.dividend <= 64'h1_0000_0000;
                div_req.divisor  <= 32'(n_new - 1'b1);
                state            <= ST_WDIV;
              end
            end
          end
        end
        ST_WDIV: begin
          if (div_rsp.done) begin
            wk_q    <= div_rsp.quotient[31:0];
            wk_r    <= div_rsp.remainder[CW-1:0];
            bin     <= '0;
            kq      <= '0;
            kr      <= '0;
            row_min <= '0;
            row_max <= MAX_INIT;
            state   <= ST_BIN;
          end
        end
        ST_BIN: begin
          // The scaled bin position bin*(N/2-1)/BINS runs as a quotient and remainder that
          // grow by N/2-1 per bin; the remainder is brought below BINS one subtraction a cycle.
          if (kr >= KW'(BINS)) begin
            kr <= kr - KW'(BINS);
            kq <= kq + 1'b1;
          end else begin
            // Transform index k is one past the scaled bin position.
            div_req.start    <= 1'b1;
            div_req.dividend <= (64'(kq) + 64'd1) << 32;
            div_req.divisor  <= 32'(n);
            state            <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            pk_q  <= div_rsp.quotient[31:0];
            pk_r  <= div_rsp.remainder[CW-1:0];
            i     <= '0;
            w_q   <= '0;
            w_r   <= '0;
            d_q   <= '0;
            d_r   <= '0;
            re    <= '0;
            im    <= '0;
            state <= ST_SRD;
          end
        end
        ST_SRD: begin
          sin_req.start <= 1'b1;
          sin_req.phase <= w_q + QUARTER;
          state         <= ST_WIN;
        end
        ST_WIN: begin
          if (sin_rsp.done) begin
            win   <= 16'((17'sd32768 - 17'(sin_rsp.value)) >>> 1);
            state <= ST_XW;
          end
        end
        ST_XW: begin
          xw            <= sample_rd * win;
          sin_req.start <= 1'b1;
          sin_req.phase <= d_q + QUARTER;
          state         <= ST_COS;
        end
        ST_COS: begin
          if (sin_rsp.done) begin
            trig  <= sin_rsp.value;
            state <= ST_MRE;
          end
        end
        ST_MRE: begin
          re            <= re + ACC_W'(xt);
          sin_req.start <= 1'b1;
          sin_req.phase <= d_q;
          state         <= ST_SIN;
        end
        ST_SIN: begin
          if (sin_rsp.done) begin
            trig  <= sin_rsp.value;
            state <= ST_MIM;
          end
        end
        ST_MIM: begin
          im  <= im - ACC_W'(xt);
          w_q <= w_q_next;
          w_r <= w_r_next;
          d_q <= d_q_next;
          d_r <= d_r_next;
          if (i == nm1[AW-1:0]) begin
            state <= ST_ABS;
          end else begin
            i     <= i + 1'b1;
            state <= ST_SRD;
          end
        end
        ST_ABS: begin
          mag_a <= re[ACC_W-1] ? ACC_W'(-re) : ACC_W'(re);
          mag_b <= im[ACC_W-1] ? ACC_W'(-im) : ACC_W'(im);
          sh    <= '0;
          state <= ST_NORM;
        end
        ST_NORM: begin
          // Both parts drop bits together until the larger fits in 31 bits.
          if (|ab_or[ACC_W-1:31]) begin
            mag_a <= mag_a >> 1;
            mag_b <= mag_b >> 1;
            sh    <= sh + 1'b1;
          end else begin
            state <= ST_SQA;
          end
        end
        ST_SQA: begin
          sq_x  <= 64'(sq_prod);
          state <= ST_SQB;
        end
        ST_SQB: begin
          sq_x   <= sq_x + 64'(sq_prod);
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          it_cnt <= '0;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_fit) begin
            sq_x   <= sq_x - sq_sum;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          it_cnt <= it_cnt + 1'b1;
          if (it_cnt == 5'd31) begin
            state <= ST_MST;
          end
        end
        ST_MST: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= sq_res << sh;
          div_req.divisor  <= 32'({n, 13'b0});
          state            <= ST_MDIV;
        end
        ST_MDIV: begin
          if (div_rsp.done) begin
            // The small offset keeps an empty bin away from log of zero.
            lm    <= div_rsp.quotient + 64'd4295;
            le    <= 8'sd30;
            state <= ST_LNRM;
          end
        end
        ST_LNRM: begin
          if (|lm[63:31]) begin
            lm <= lm >> 1;
            le <= le + 8'sd1;
          end else if (!lm[30]) begin
            lm <= lm << 1;
            le <= le - 8'sd1;
          end else begin
            frac   <= '0;
            it_cnt <= '0;
            state  <= ST_LSQ;
          end
        end
        ST_LSQ: begin
          // Squaring the mantissa yields one fraction bit of the log per step.
          if (lsq_sh[31]) begin
            lm   <= 64'(lsq_sh >> 1);
            frac <= {frac[10:0], 1'b1};
          end else begin
            lm   <= 64'(lsq_sh);
            frac <= {frac[10:0], 1'b0};
          end
          it_cnt <= it_cnt + 1'b1;
          if (it_cnt == 5'd11) begin
            state <= ST_DB;
          end
        end
        ST_DB: begin
          dbacc <= db_prod + 40'sd524288;
          state <= ST_DBW;
        end
        ST_DBW: begin
          if (db < row_min) begin
            row_min <= db;
          end
          if (db > row_max) begin
            row_max <= db;
          end
          if (bin == BW'(BINS - 1)) begin
            avg_step <= '0;
            state    <= ST_AVG;
          end else begin
            bin   <= bin + 1'b1;
            kr    <= kr + KW'(half_m1);
            state <= ST_BIN;
          end
        end
        ST_AVG: begin
          avg_step <= avg_step + 1'b1;
          case (avg_step)
            3'd0: avg_acc <= avg_prod;
            3'd1: avg_acc <= avg_acc + avg_prod;
            3'd2: begin
              floor_db <= 18'((avg_acc + 40'sd32768) >>> 16);
              avg_acc  <= avg_prod;
            end
            3'd3: avg_acc <= avg_acc + avg_prod;
            default: begin
              ceil_db <= 18'((avg_acc + 40'sd32768) >>> 16);
              state   <= ST_CLAMP;
            end
          endcase
        end
        ST_CLAMP: begin
          if (ceil_db < ceil_lim) begin
            ceil_db <= ceil_lim;
          end
          state <= ST_RANGE;
        end
        ST_RANGE: begin
          range_db <= (span < MIN_RANGE) ? 18'(MIN_RANGE) : 18'(span);
          bin      <= '0;
          state    <= ST_PRD;
        end
        ST_PRD: begin
          state <= ST_PNUM;
        end
        ST_PNUM: begin
          if (num[18] || num == 19'sd0) begin
            lv    <= '0;
            state <= ST_PCOL;
          end else if (num >= $signed({1'b0, range_db})) begin
            lv    <= 17'd65536;
            state <= ST_PCOL;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= 64'(num[17:0]) << 16;
            div_req.divisor  <= 32'(range_db);
            state            <= ST_LDIV;
          end
        end
        ST_LDIV: begin
          if (div_rsp.done) begin
            lv    <= div_rsp.quotient[16:0];
            state <= ST_PCOL;
          end
        end
        ST_PCOL: begin
          rprod <= r_mul;
          gprod <= (g5 > 19'd65536) ? g_mul : '0;
          bprod <= 27'd23396352 + b_mul;
          state <= ST_PGRN;
        end
        ST_PGRN: begin
          // Green divides by five times 2^16: shift, then a reciprocal exact in this range.
          gq    <= gq_mul;
          state <= ST_PEMIT;
        end
        ST_PEMIT: begin
          if (pix_emit) begin
            row_index <= 8'(cur_row);
            bin_index <= 6'(bin);
            red       <= (rprod[26:16] > 11'd255) ? 8'd255 : rprod[23:16];
            green     <= (gq[27:18] > 10'd255) ? 8'd255 : gq[25:18];
            blue      <= (bprod[26:18] > 9'd255) ? 8'd255 : bprod[25:18];
            row_done  <= (bin == BW'(BINS - 1));
            if (bin == BW'(BINS - 1)) begin
              cur_row <= (cur_row == RW'(ROWS - 1)) ? '0 : cur_row + 1'b1;
              state   <= ST_IDLE;
            end else begin
              bin   <= bin + 1'b1;
              state <= ST_PRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### dv/wfsr_row_checker.sv
// Checker for the waterfall spectrum row: watches both channels, predicts pixels, compares.
`timescale 1ns / 1ps
module wfsr_row_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         row_index,
  input  logic [5:0]         bin_index,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               row_done,
  output int                 fail_count,
  output int                 pixels_owed
);

  localparam int NBINS  = wfsr_pkg::BINS_DEFAULT;
  localparam int NROWS  = wfsr_pkg::ROWS_DEFAULT;
  localparam int NCHUNK = wfsr_pkg::MAX_CHUNK_DEFAULT;

  typedef struct packed {
    logic [7:0] row;
    logic [5:0] bin;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       done;
  } pixel_t;

  pixel_t      owed_px[$];
  shortint     chunk_buf[NCHUNK];
  int          chunk_len;
  shortint     bin_db[NBINS];
  int          floor_q;
  int          ceil_q;
  int          row_ptr;
  int          win[NCHUNK];

  function automatic longint qsin(longint x);
    longint x2, t, y;
    x2 = (x * x) >>> 16;
    t  = 168;
    t  = -4909 + ((t * x2) >>> 16);
    t  = 83565 + ((t * x2) >>> 16);
    t  = -677340 + ((t * x2) >>> 16);
    t  = 1647099 + ((t * x2) >>> 16);
    y  = (((t * x) >>> 16) + 16) >>> 5;
    if (y > 32767) y = 32767;
    if (y < 0) y = 0;
    return y;
  endfunction

  function automatic longint sin_q15(bit [31:0] p);
    longint f, s;
    f = longint'(p[29:14]);
    s = qsin(p[30] ? 65536 - f : f);
    return p[31] ? -s : s;
  endfunction

  function automatic bit [31:0] turn_frac(longint unsigned r, longint unsigned d);
    longint unsigned t;
    t = (r << 32) / d;
    return t[31:0];
  endfunction

  function automatic int bit_len(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bv;
    res = 0;
    bv  = 64'h4000_0000_0000_0000;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Magnitude of one bin in dB, Q8.8.
  function automatic int bin_level_db(longint re, longint im, int n);
    longint unsigned a, b, r, v, m;
    int     len, sh, e;
    longint fr, l12;
    a   = (re < 0) ? -re : re;
    b   = (im < 0) ? -im : im;
    len = bit_len(a > b ? a : b);
    sh  = (len > 31) ? len - 31 : 0;
    a   = a >> sh;
    b   = b >> sh;
    r   = isqrt(a * a + b * b);
    v   = ((r << sh) / (longint'(n) << 13)) + 4295;
    e   = bit_len(v) - 1;
    m   = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    fr  = 0;
    for (int i = 0; i < 12; i++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m  = m >> 1;
        fr = fr | 1;
      end
    end
    l12 = (longint'(e) - 32) * 4096 + fr;
    return int'((l12 * 394566 + (1 << 19)) >>> 20);
  endfunction

  // Computes one spectrum row from the stored chunk and queues its pixels.
  task automatic build_row(int n);
    longint re, im, xw, k, num, lv, rr, gg, bb;
    int     half, rmin, rmax, db, rng;
    bit [31:0] ph;
    pixel_t px;
    for (int i = 0; i < n; i++)
      win[i] = int'((32768 - sin_q15(turn_frac(i, n - 1) + 32'h4000_0000)) >>> 1);
    half = n / 2;
    rmin = 0;
    rmax = -30720;
    for (int bn = 0; bn < NBINS; bn++) begin
      k  = 1 + (longint'(bn) * (half - 1)) / NBINS;
      re = 0;
      im = 0;
      for (int i = 0; i < n; i++) begin
        xw = longint'(chunk_buf[i]) * win[i];
        ph = turn_frac((k * i) % n, n);
        re += xw * sin_q15(ph + 32'h4000_0000);
        im -= xw * sin_q15(ph);
      end
      db = bin_level_db(re, im, n);
      if (db < rmin) rmin = db;
      if (db > rmax) rmax = db;
      bin_db[bn] = shortint'(db);
    end
    floor_q = int'((longint'(floor_q) * 62915 + longint'(rmin) * 2621 + 32768) >>> 16);
    ceil_q  = int'((longint'(ceil_q) * 58982 + longint'(rmax) * 6554 + 32768) >>> 16);
    if (ceil_q < floor_q + 4608) ceil_q = floor_q + 4608;
    rng = ceil_q - floor_q;
    if (rng < 6144) rng = 6144;
    for (int x = 0; x < NBINS; x++) begin
      num = longint'(bin_db[x]) - floor_q;
      if (num <= 0) lv = 0;
      else if (num >= rng) lv = 65536;
      else lv = (num * 65536) / rng;
      rr = (lv * 561) >>> 16;
      if (rr > 255) rr = 255;
      gg = 5 * lv - 65536;
      gg = (gg <= 0) ? 0 : (gg * 459) / 327680;
      if (gg > 255) gg = 255;
      bb = (23396352 + (65536 - lv) * 663) >>> 18;
      if (bb > 255) bb = 255;
      px.row  = row_ptr[7:0];
      px.bin  = x[5:0];
      px.r    = rr[7:0];
      px.g    = gg[7:0];
      px.b    = bb[7:0];
      px.done = (x == NBINS - 1);
      owed_px = {owed_px, px};
    end
    row_ptr = (row_ptr + 1) % NROWS;
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    int     n;
    if (rst) begin
      chunk_len = 0;
      floor_q   = -18432;
      ceil_q    = -4608;
      row_ptr   = 0;
      owed_px.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{row_index, bin_index, red, green, blue, row_done};
        if (owed_px.size() == 0) begin
          $display("%0t: unexpected pixel row=%0d bin=%0d rgb=%0d,%0d,%0d done=%0d", $time,
                   got.row, got.bin, got.r, got.g, got.b, got.done);
          fail_count++;
        end else begin
          want = owed_px[0];
          owed_px.delete(0);
          if (got !== want) begin
            $display("%0t: pixel mismatch expected row=%0d bin=%0d rgb=%0d,%0d,%0d done=%0d",
                     $time, want.row, want.bin, want.r, want.g, want.b, want.done);
            $display("%0t:                actual row=%0d bin=%0d rgb=%0d,%0d,%0d done=%0d",
                     $time, got.row, got.bin, got.r, got.g, got.b, got.done);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (chunk_len < NCHUNK) begin
          chunk_buf[chunk_len] = sample;
          chunk_len++;
        end
        if (last_sample) begin
          n = chunk_len;
          chunk_len = 0;
          if (n >= 8) build_row(n);
        end
      end
    end
    pixels_owed = owed_px.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top: drives sample chunks and output stalls, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  // Cycles with no transfer on either side before the run is declared hung, set well above
  // the processing time of the slowest chunk used here (32 samples).
  localparam int IDLE_LIMIT = 400000;
  // Longer than one short chunk takes, so the first pixel waits and the input backs up.
  localparam int HOLD_CYCLES = 60000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] sample = '0;
  logic               last_sample = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         row_index;
  logic [5:0]         bin_index;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               row_done;
  int                 fail_count;
  int                 pixels_owed;
  int                 samples_sent;
  bit                 hold_req = 1'b0;
  bit                 hold_done = 1'b0;

  always #5 clk = ~clk;

  waterfall_spectrum_row i_dut (
    .clk, .rst, .in_valid, .in_ready, .sample, .last_sample,
    .out_valid, .out_ready, .row_index, .bin_index, .red, .green, .blue, .row_done
  );

  wfsr_row_checker i_chk (
    .clk, .rst, .in_valid, .in_ready, .sample, .last_sample,
    .out_valid, .out_ready, .row_index, .bin_index, .red, .green, .blue, .row_done,
    .fail_count, .pixels_owed
  );

  // Offers one sample and holds it until the transfer. Called at a falling edge and returns
  // at one; valid stays high into the next sample unless a gap is drawn.
  task automatic push_sample(input logic signed [15:0] s, input bit last);
    int gap;
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
    if ($urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 120);
      else gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sends one chunk. Shapes: 0 random full scale, 1 quiet random, 2 alternating extremes,
  // 3 constant value given by level, 4 silence.
  task automatic push_chunk(input int len, input int shape, input logic signed [15:0] level);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: s = 16'($urandom);
        1: s = 16'($signed($urandom_range(0, 511)) - 256);
        2: s = i[0] ? 16'sh7fff : 16'sh8000;
        3: s = level;
        default: s = '0;
      endcase
      push_sample(s, i == len - 1);
    end
  endtask

  // The sink: random ready with mostly short stalls, a few long ones, stretches of no stall,
  // and one long hold-off on request so that the block backs up into its input.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 40);
        end else begin
          out_ready <= 1'b0;
          n = (n < 95) ? $urandom_range(1, 4) : $urandom_range(30, 250);
        end
        repeat (n) @(negedge clk);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int len, shape;
    samples_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed chunks: extremes, DC, silence, the minimum length, short chunks.
    push_chunk(8, 2, '0);
    push_chunk(8, 3, 16'sh7fff);
    push_chunk(3, 0, '0);
    push_chunk(9, 3, 16'sh8000);
    push_chunk(8, 4, '0);
    push_chunk(1, 3, 16'sh7fff);
    push_chunk(7, 0, '0);
    push_chunk(10, 0, '0);

    // Pause the source until every pixel of the directed rows has been taken.
    in_valid <= 1'b0;
    while (pixels_owed != 0) @(negedge clk);

    // Long sink hold-off while the next chunks keep coming, so the pixel path backs up.
    hold_req = 1'b1;
    push_chunk(8, 0, '0);
    push_chunk(9, 1, '0);

    // One longer chunk, then random chunks, mostly well-formed with a few short ones.
    push_chunk(32, 0, '0);
    while (samples_sent < 230) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 7);
      else len = $urandom_range(8, 14);
      shape = $urandom_range(0, 9);
      shape = (shape < 6) ? 0 : (shape < 8) ? 1 : (shape < 9) ? 2 : 3;
      push_chunk(len, shape, 16'($urandom));
    end
    in_valid    <= 1'b0;
    last_sample <= 1'b0;

    while (pixels_owed != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pixels_owed == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### waterfall_spectrum_row.f
rtl/core/wfsr_pkg.sv
rtl/core/wfsr_div.sv
rtl/core/wfsr_sin.sv
rtl/core/waterfall_spectrum_row.sv
dv/wfsr_row_checker.sv
dv/tb_top.sv
